// ===== hw/rtl/tod_pkg.sv =====
`timescale 1ns / 1ps

package tod_pkg;

  localparam logic [4:0] HourMax   = 5'd23;
  localparam logic [5:0] MinuteMax = 6'd59;
  localparam logic [5:0] SecondMax = 6'd59;
  localparam logic [9:0] MilliMax  = 10'd999;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [9:0] millis;
  } tod_time_t;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2,
    OP_CMP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_LATER   = 2'd1,
    ORD_EARLIER = 2'd2
  } order_t;

endpackage

// ===== hw/rtl/time_of_day_accumulator_top.sv =====
`timescale 1ns / 1ps
// an input transaction loads the input register, and the result register loads from it
// when it advances, after which the result transaction is offered on the outputs
// one transaction per cycle while out_stall is low, as the add/subtract and bcd path is combinational
// under out_stall the input register takes one more transaction, then in_stall rises
// reset (rst, synchronous, active high) clears the stored time to 00:00:00.000
// and empties both the input and result registers

module time_of_day_accumulator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [4:0]  hours_in,
  input  logic [5:0]  minutes_in,
  input  logic [5:0]  seconds_in,
  input  logic [9:0]  millis_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  hours_out,
  output logic [5:0]  minutes_out,
  output logic [5:0]  seconds_out,
  output logic [9:0]  millis_out,
  output logic [1:0]  order,
  output logic [35:0] display_digits
);
  import tod_pkg::*;

  logic      in_full;
  op_t       in_op;
  tod_time_t in_opnd;
  tod_time_t cur;
  tod_time_t cur_next;
  order_t    ord_next;
  logic [35:0] digits_next;
  logic      advance;
  logic      load;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign load     = in_valid && !in_stall;

  tod_alu u_alu (
    .op      (in_op),
    .stored  (cur),
    .operand (in_opnd),
    .result  (cur_next),
    .order   (ord_next)
  );

  tod_bcd u_bcd (
    .value  (cur_next),
    .digits (digits_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      cur       <= '0;
    end else begin
      if (load) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        cur       <= cur_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      in_op   <= op_t'(opcode);
      in_opnd <= '{hours: hours_in, minutes: minutes_in,
                   seconds: seconds_in, millis: millis_in};
    end
    if (advance) begin
      hours_out      <= cur_next.hours;
      minutes_out    <= cur_next.minutes;
      seconds_out    <= cur_next.seconds;
      millis_out     <= cur_next.millis;
      order          <= ord_next;
      display_digits <= digits_next;
    end
  end

endmodule

// ===== hw/rtl/tod_alu.sv =====
`timescale 1ns / 1ps

module tod_alu (
  input  tod_pkg::op_t      op,
  input  tod_pkg::tod_time_t stored,
  input  tod_pkg::tod_time_t operand,
  output tod_pkg::tod_time_t result,
  output tod_pkg::order_t    order
);
  import tod_pkg::*;

  localparam logic [10:0] MilliMod  = 11'd1000;
  localparam logic [6:0]  SixtyMod  = 7'd60;
  localparam logic [5:0]  HourMod   = 6'd24;

  tod_time_t opnd;
  tod_time_t sum_t;
  tod_time_t diff_t;
  tod_time_t sat_hi;

  logic [10:0] ms_sum, ms_diff;
  logic [6:0]  s_sum, s_diff, m_sum, m_diff;
  logic [5:0]  h_sum, h_diff;
  logic        c0, c1, c2, ovf;
  logic        b0, b1, b2, unf;
  logic        later, earlier;

  // clamp operand fields to legal range
  always_comb begin
    opnd.hours   = (operand.hours   > HourMax)   ? HourMax   : operand.hours;
    opnd.minutes = (operand.minutes > MinuteMax) ? MinuteMax : operand.minutes;
    opnd.seconds = (operand.seconds > SecondMax) ? SecondMax : operand.seconds;
    opnd.millis  = (operand.millis  > MilliMax)  ? MilliMax  : operand.millis;
  end

  assign sat_hi = '{hours: HourMax, minutes: MinuteMax, seconds: SecondMax, millis: MilliMax};

  // mixed-radix add
  always_comb begin
    ms_sum = {1'b0, stored.millis} + {1'b0, opnd.millis};
    c0     = (ms_sum >= MilliMod);
    if (c0) ms_sum = ms_sum - MilliMod;
    s_sum  = {1'b0, stored.seconds} + {1'b0, opnd.seconds} + {6'd0, c0};
    c1     = (s_sum >= SixtyMod);
    if (c1) s_sum = s_sum - SixtyMod;
    m_sum  = {1'b0, stored.minutes} + {1'b0, opnd.minutes} + {6'd0, c1};
    c2     = (m_sum >= SixtyMod);
    if (c2) m_sum = m_sum - SixtyMod;
    h_sum  = {1'b0, stored.hours} + {1'b0, opnd.hours} + {5'd0, c2};
    ovf    = (h_sum >= HourMod);
    sum_t.hours   = h_sum[4:0];
    sum_t.minutes = m_sum[5:0];
    sum_t.seconds = s_sum[5:0];
    sum_t.millis  = ms_sum[9:0];
  end

  // mixed-radix subtract
  always_comb begin
    ms_diff = {1'b0, stored.millis} - {1'b0, opnd.millis};
    b0      = ms_diff[10];
    if (b0) ms_diff = ms_diff + MilliMod;
    s_diff  = {1'b0, stored.seconds} - {1'b0, opnd.seconds} - {6'd0, b0};
    b1      = s_diff[6];
    if (b1) s_diff = s_diff + SixtyMod;
    m_diff  = {1'b0, stored.minutes} - {1'b0, opnd.minutes} - {6'd0, b1};
    b2      = m_diff[6];
    if (b2) m_diff = m_diff + SixtyMod;
    h_diff  = {1'b0, stored.hours} - {1'b0, opnd.hours} - {5'd0, b2};
    unf     = h_diff[5];
    diff_t.hours   = h_diff[4:0];
    diff_t.minutes = m_diff[5:0];
    diff_t.seconds = s_diff[5:0];
    diff_t.millis  = ms_diff[9:0];
  end

  assign later   = (stored > opnd);
  assign earlier = (stored < opnd);

  always_comb begin
    result = stored;
    order  = ORD_EQUAL;
    case (op)
      OP_SET: result = opnd;
      OP_ADD: result = ovf ? sat_hi : sum_t;
      OP_SUB: result = unf ? '0 : diff_t;
      OP_CMP: begin
        if (later) order = ORD_LATER;
        else if (earlier) order = ORD_EARLIER;
      end
      default: result = stored;
    endcase
  end

endmodule

// ===== hw/rtl/tod_bcd.sv =====
`timescale 1ns / 1ps

module tod_bcd (
  input  tod_pkg::tod_time_t value,
  output logic [35:0]        digits
);
  import tod_pkg::*;

  function automatic logic [7:0] bcd_pair(input logic [6:0] v);
    logic [3:0] t;
    logic [6:0] r;
    t = '0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(k * 10)) t = 4'(k);
    end
    r = v - 7'(t * 10);
    return {t, r[3:0]};
  endfunction

  logic [3:0] ms_hund;
  logic [9:0] ms_rem;

  // hundreds digit of milliseconds by threshold count
  always_comb begin
    ms_hund = '0;
    for (int k = 1; k < 10; k++) begin
      if (value.millis >= 10'(k * 100)) ms_hund = 4'(k);
    end
    ms_rem = value.millis - 10'(ms_hund * 100);
  end

  assign digits = {bcd_pair({2'b00, value.hours}),
                   bcd_pair({1'b0, value.minutes}),
                   bcd_pair({1'b0, value.seconds}),
                   ms_hund,
                   bcd_pair(ms_rem[6:0])};

endmodule
